@@ sv/b64sd_pkg.sv @@
// Shared types, character constants and the character classifier
// for the base64 stream decoder. No dependencies.
package b64sd_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

	// offsets that map a character code onto its alphabet value
	localparam logic [7:0] OFS_UPPER = CHAR_UC_A;
	localparam logic [7:0] OFS_LOWER = CHAR_LC_A - 8'd26;
	localparam logic [7:0] OFS_DIGIT = 8'd52 - CHAR_ZERO;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// queue between classifier and decoder, power of two
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CLS_ALPHA,
		CLS_LINEBRK,
		CLS_TERM,
		CLS_OTHER
	} char_cls_t;

	typedef struct packed {
		logic [5:0] sextet;
		char_cls_t  cls;
		logic       som;
		logic       eoi;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic item_t classify(logic [7:0] c, logic som, logic eoi);
		item_t it;
		it.som    = som;
		it.eoi    = eoi;
		it.sextet = '0;
		it.cls    = CLS_OTHER;
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			it.sextet = 6'(c - OFS_UPPER);
			it.cls    = CLS_ALPHA;
		end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			it.sextet = 6'(c - OFS_LOWER);
			it.cls    = CLS_ALPHA;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			it.sextet = 6'(c + OFS_DIGIT);
			it.cls    = CLS_ALPHA;
		end else if (c == CHAR_PLUS) begin
			it.sextet = SEXTET_PLUS;
			it.cls    = CLS_ALPHA;
		end else if (c == CHAR_SLASH) begin
			it.sextet = SEXTET_SLASH;
			it.cls    = CLS_ALPHA;
		end else if (c == CHAR_CR || c == CHAR_LF) begin
			it.cls = CLS_LINEBRK;
		end else if (c == CHAR_NUL || c == CHAR_EQ) begin
			it.cls = CLS_TERM;
		end
		return it;
	endfunction

endpackage

@@ sv/b64sd_if.sv @@
// Valid/ready stream interfaces for the base64 stream decoder:
// encoded character words in, decoded byte words out. No dependencies.
interface b64sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       start_of_message;
	logic       end_of_input;

	modport source (output valid, output in_char, output start_of_message,
		output end_of_input, input ready);
	modport sink (input valid, input in_char, input start_of_message,
		input end_of_input, output ready);
endinterface

interface b64sd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       message_done;

	modport source (output valid, output out_byte, output byte_valid,
		output message_done, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input message_done, output ready);
endinterface

@@ sv/b64sd_front.sv @@
// Front end: accepts character words and classifies each into an alphabet
// value and a class. Depends on b64sd_pkg and b64sd_in_if.
module b64sd_front (
	b64sd_in_if.sink           in_stream,
	input  b64sd_pkg::q_status_t q_stat,
	output logic               push,
	output b64sd_pkg::item_t   push_item
);
	import b64sd_pkg::*;

	assign in_stream.ready = !q_stat.full;
	assign push            = in_stream.valid && !q_stat.full;
	assign push_item       = classify(in_stream.in_char, in_stream.start_of_message,
		in_stream.end_of_input);

endmodule

@@ sv/b64sd_queue.sv @@
// Short FIFO of classified words between front end and decoder.
// Depends on b64sd_pkg.
module b64sd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64sd_pkg::item_t     push_item,
	input  logic                 pop,
	output b64sd_pkg::item_t     pop_item,
	output b64sd_pkg::q_status_t q_stat
);
	import b64sd_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_stat.full  = (count_q == CW'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/b64sd_back.sv @@
// Decoder back end: group position, previous value and stop flag, with a
// registered output word. Depends on b64sd_pkg and b64sd_out_if.
module b64sd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64sd_pkg::q_status_t q_stat,
	input  b64sd_pkg::item_t     pop_item,
	output logic                 pop,
	b64sd_out_if.source          out_stream
);
	import b64sd_pkg::*;

	logic [1:0] pos_q;
	logic [5:0] prev_q;
	logic       stopped_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       done_q;

	logic [1:0] pos, pos_n;
	logic [5:0] prev, prev_n;
	logic       stop, stop_n;
	logic [7:0] byte_n;
	logic       valid_n;
	logic       done_n;

	// output register frees up when empty or being drained this cycle
	assign pop = !q_stat.empty && (!out_valid_q || out_stream.ready);

	assign out_stream.valid        = out_valid_q;
	assign out_stream.out_byte     = byte_q;
	assign out_stream.byte_valid   = byte_valid_q;
	assign out_stream.message_done = done_q;

	always_comb begin
		pos  = pos_q;
		prev = prev_q;
		stop = stopped_q;
		if (pop_item.som) begin
			pos  = '0;
			prev = '0;
			stop = 1'b0;
		end
		pos_n   = pos;
		prev_n  = prev;
		byte_n  = '0;
		valid_n = 1'b0;
		done_n  = 1'b0;
		if (!stop) begin
			unique case (pos)
				2'd0: begin
					if (pop_item.cls == CLS_TERM) begin
						done_n = 1'b1;
					end else if (pop_item.cls != CLS_LINEBRK) begin
						// unknown characters enter the group as zero
						prev_n = pop_item.sextet;
						pos_n  = 2'd1;
					end
				end
				2'd1: begin
					valid_n = 1'b1;
					if (pop_item.cls == CLS_ALPHA) begin
						byte_n = {prev, pop_item.sextet[5:4]};
						prev_n = pop_item.sextet;
						pos_n  = 2'd2;
					end else begin
						byte_n = {prev, 2'b00};
						done_n = 1'b1;
					end
				end
				2'd2: begin
					if (pop_item.cls == CLS_ALPHA) begin
						byte_n  = {prev[3:0], pop_item.sextet[5:2]};
						valid_n = 1'b1;
						prev_n  = pop_item.sextet;
						pos_n   = 2'd3;
					end else begin
						done_n = 1'b1;
					end
				end
				2'd3: begin
					if (pop_item.cls == CLS_ALPHA) begin
						byte_n  = {prev[1:0], pop_item.sextet};
						valid_n = 1'b1;
						prev_n  = pop_item.sextet;
						pos_n   = 2'd0;
					end else begin
						done_n = 1'b1;
					end
				end
				default: begin
					pos_n = pos;
				end
			endcase
			if (pop_item.eoi) begin
				done_n = 1'b1;
			end
		end
		stop_n = stop || done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prev_q      <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q       <= pos_n;
				prev_q      <= prev_n;
				stopped_q   <= stop_n;
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q       <= byte_n;
			byte_valid_q <= valid_n;
			done_q       <= done_n;
		end
	end

endmodule

@@ sv/base64_stream_decoder.sv @@
// Base64 (standard alphabet) stream decoder, one character word per item.
// Depends on b64sd_pkg, b64sd_if, b64sd_front, b64sd_queue, b64sd_back.
//
// Channels: in_stream carries in_char with start_of_message and
// end_of_input; out_stream returns exactly one word per character with
// out_byte, byte_valid and message_done. Both are valid/ready; a word
// moves on a rising edge with valid and ready high.
// A character is classified on acceptance and written to a two-entry
// queue; the decoder takes it from the queue and updates group position,
// previous value and stop flag, registering the result word.
// The character passes through a queue entry and then the registered
// output word. Throughput: one character per cycle while out_stream is ready,
// set by the decode loop around the group state in the back end.
// Receiver stall: the output word holds, the decoder stops draining the
// queue, and in_stream.ready drops once the queue is full; nothing is lost.
// Reset (arst_n low): queue emptied, group position, previous value and
// stop flag cleared, no output word pending.
module base64_stream_decoder (
	input logic          clk,
	input logic          arst_n,
	b64sd_in_if.sink     in_stream,
	b64sd_out_if.source  out_stream
);
	import b64sd_pkg::*;

	logic      push;
	logic      pop;
	item_t     push_item;
	item_t     pop_item;
	q_status_t q_stat;

	b64sd_front u_front (
		.in_stream (in_stream),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	b64sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	b64sd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_stream (out_stream)
	);

endmodule

@@ verif/base64_stream_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_decoder: random base64 messages and noise in,
// one decoded word per character out, predicted and compared word by word.
// Depends on b64sd_pkg, b64sd_if and the decoder RTL.
module base64_stream_decoder_test;
	import b64sd_pkg::*;

	localparam int LIVE_TARGET     = 750;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int END_SETTLE      = 8;
	localparam int MAX_REPORTS     = 50;

	typedef enum int {
		FAULT_NONE,
		FAULT_BAD_CHAR,
		FAULT_NO_SOM,
		FAULT_NO_EOI
	} msg_fault_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       message_done;
	} decoded_word_t;

	// Tracks group position, previous sextet and stop flag; queues the word due per character.
	class byte_decode_tracker;
		bit [1:0]      grp_pos;
		bit [5:0]      prev_sextet;
		bit            halted;
		decoded_word_t due_words[$];
		int            errors;

		function new();
			grp_pos     = '0;
			prev_sextet = '0;
			halted      = 1'b0;
			errors      = 0;
		endfunction

		static function bit sextet_value(input logic [7:0] c, output bit [5:0] v);
			bit [7:0] t;
			t = 8'd0;
			sextet_value = 1'b1;
			if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
				t = c - CHAR_UC_A;
			else if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
				t = c - CHAR_LC_A + 8'd26;
			else if (c >= CHAR_ZERO && c <= CHAR_NINE)
				t = c - CHAR_ZERO + 8'd52;
			else if (c == CHAR_PLUS)
				t = 8'd62;
			else if (c == CHAR_SLASH)
				t = 8'd63;
			else
				sextet_value = 1'b0;
			v = t[5:0];
		endfunction

		// Returns 1 when the character was decoded rather than ignored.
		function bit note_char(input logic [7:0] c, input logic som, input logic eoi);
			decoded_word_t w;
			bit [5:0]      v;
			bit            ok;
			w = '0;
			if (som) begin
				grp_pos     = '0;
				prev_sextet = '0;
				halted      = 1'b0;
			end
			if (halted) begin
				due_words.push_back(w);
				return 1'b0;
			end
			ok = sextet_value(c, v);
			case (grp_pos)
				2'd0: begin
					if (c == CHAR_CR || c == CHAR_LF) begin
						// line break between groups
					end else if (c == CHAR_NUL || c == CHAR_EQ) begin
						w.message_done = 1'b1;
					end else begin
						prev_sextet = v;
						grp_pos     = 2'd1;
					end
				end
				2'd1: begin
					w.byte_valid = 1'b1;
					if (ok) begin
						w.out_byte  = {prev_sextet, v[5:4]};
						prev_sextet = v;
						grp_pos     = 2'd2;
					end else begin
						// truncated group still yields the upper bits
						w.out_byte     = {prev_sextet, 2'b00};
						w.message_done = 1'b1;
					end
				end
				2'd2: begin
					if (ok) begin
						w.out_byte   = {prev_sextet[3:0], v[5:2]};
						w.byte_valid = 1'b1;
						prev_sextet  = v;
						grp_pos      = 2'd3;
					end else begin
						w.message_done = 1'b1;
					end
				end
				default: begin
					if (ok) begin
						w.out_byte   = {prev_sextet[1:0], v};
						w.byte_valid = 1'b1;
						prev_sextet  = v;
						grp_pos      = 2'd0;
					end else begin
						w.message_done = 1'b1;
					end
				end
			endcase
			if (eoi)
				w.message_done = 1'b1;
			if (w.message_done)
				halted = 1'b1;
			due_words.push_back(w);
			return 1'b1;
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		task report_mismatch(input string msg);
			if (errors < MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_word(input decoded_word_t got);
			decoded_word_t want;
			if (due_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%02h valid=%b done=%b",
					got.out_byte, got.byte_valid, got.message_done));
				return;
			end
			want = due_words.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %02h, want %02h",
					got.out_byte, want.out_byte));
			if (got.byte_valid !== want.byte_valid)
				report_mismatch($sformatf("byte_valid %b, want %b",
					got.byte_valid, want.byte_valid));
			if (got.message_done !== want.message_done)
				report_mismatch($sformatf("message_done %b, want %b",
					got.message_done, want.message_done));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   hold_off_req;
	int   live_count;
	int   idle_cycles;
	byte_decode_tracker tracker;

	b64sd_in_if  in_ch();
	b64sd_out_if out_ch();

	base64_stream_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_ch),
		.out_stream (out_ch)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
		if (s < 6'd26)
			return CHAR_UC_A + 8'(s);
		else if (s < 6'd52)
			return CHAR_LC_A + 8'(s) - 8'd26;
		else if (s < 6'd62)
			return CHAR_ZERO + 8'(s) - 8'd52;
		else if (s == 6'd62)
			return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	task automatic send_word(input logic [7:0] c, input logic som, input logic eoi);
		int gap;
		in_ch.valid            <= 1'b1;
		in_ch.in_char          <= c;
		in_ch.start_of_message <= som;
		in_ch.end_of_input     <= eoi;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		if (tracker.note_char(c, som, eoi))
			live_count++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (tracker.pending() > 0)
			@(negedge clk);
	endtask

	task automatic send_message(input msg_fault_t fault);
		logic [7:0] chars[$];
		logic [7:0] b0, b1, b2;
		int         nbytes, rem;
		bit         pad, eoi_last;
		nbytes   = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 9);
		pad      = $urandom_range(0, 2) != 0;
		eoi_last = $urandom_range(0, 4) != 0;
		rem      = nbytes;
		while (rem >= 3) begin
			b0 = 8'($urandom_range(0, 255));
			b1 = 8'($urandom_range(0, 255));
			b2 = 8'($urandom_range(0, 255));
			chars.push_back(char_of_sextet(b0[7:2]));
			chars.push_back(char_of_sextet({b0[1:0], b1[7:4]}));
			chars.push_back(char_of_sextet({b1[3:0], b2[7:6]}));
			chars.push_back(char_of_sextet(b2[5:0]));
			rem -= 3;
			if ($urandom_range(0, 5) == 0) begin
				chars.push_back(CHAR_CR);
				chars.push_back(CHAR_LF);
			end else if ($urandom_range(0, 9) == 0) begin
				chars.push_back(CHAR_LF);
			end
		end
		b0 = 8'($urandom_range(0, 255));
		b1 = 8'($urandom_range(0, 255));
		if (rem == 1) begin
			chars.push_back(char_of_sextet(b0[7:2]));
			chars.push_back(char_of_sextet({b0[1:0], 4'b0000}));
			if (pad) begin
				chars.push_back(CHAR_EQ);
				chars.push_back(CHAR_EQ);
			end
		end else if (rem == 2) begin
			chars.push_back(char_of_sextet(b0[7:2]));
			chars.push_back(char_of_sextet({b0[1:0], b1[7:4]}));
			chars.push_back(char_of_sextet({b1[3:0], 2'b00}));
			if (pad)
				chars.push_back(CHAR_EQ);
		end else if (pad || chars.size() == 0) begin
			chars.push_back($urandom_range(0, 1) ? CHAR_EQ : CHAR_NUL);
		end
		if (fault == FAULT_BAD_CHAR)
			chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
		foreach (chars[i])
			send_word(chars[i], i == 0 && fault != FAULT_NO_SOM,
				i == chars.size() - 1 && eoi_last && fault != FAULT_NO_EOI);
	endtask

	// result side: check, then decide ready for the next edge
	initial begin : result_side
		int stall_left;
		bit next_ready;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				tracker.check_word({out_ch.out_byte, out_ch.byte_valid, out_ch.message_done});
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				next_ready = 1'b0;
				stall_left--;
			end else begin
				next_ready = 1'b1;
				if (!steady)
					stall_left = pick_gap();
			end
			@(negedge clk);
			out_ch.ready <= next_ready;
		end
	end

	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no word moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, tracker.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int r, n;
		bit hold_done, drain_done;
		tracker                = new();
		hold_done              = 1'b0;
		drain_done             = 1'b0;
		steady                 = 1'b0;
		hold_off_req           = 1'b0;
		live_count             = 0;
		arst_n                 = 1'b0;
		in_ch.valid            = 1'b0;
		in_ch.in_char          = '0;
		in_ch.start_of_message = 1'b0;
		in_ch.end_of_input     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full group, skipped line break, padding first in group
		send_word("T", 1'b1, 1'b0);
		send_word("W", 1'b0, 1'b0);
		send_word("F", 1'b0, 1'b0);
		send_word("u", 1'b0, 1'b0);
		send_word(CHAR_CR, 1'b0, 1'b0);
		send_word(CHAR_LF, 1'b0, 1'b0);
		send_word(CHAR_EQ, 1'b0, 1'b0);
		// alphabet extremes, end of input on a full group
		send_word("/", 1'b1, 1'b0);
		send_word("+", 1'b0, 1'b0);
		send_word("9", 1'b0, 1'b0);
		send_word("z", 1'b0, 1'b1);
		// bad second char still emits a byte, then stopped
		send_word("Q", 1'b1, 1'b0);
		send_word("!", 1'b0, 1'b0);
		send_word("A", 1'b0, 1'b0);
		// junk first char counts as zero; padding third ends it
		send_word("*", 1'b1, 1'b0);
		send_word("A", 1'b0, 1'b0);
		send_word(CHAR_EQ, 1'b0, 1'b0);
		// bad fourth char
		send_word("A", 1'b1, 1'b0);
		send_word("A", 1'b0, 1'b0);
		send_word("A", 1'b0, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(CHAR_NUL, 1'b1, 1'b0);
		// end of input mid group and on a line break
		send_word("Z", 1'b1, 1'b0);
		send_word("z", 1'b0, 1'b1);
		send_word(CHAR_CR, 1'b1, 1'b1);
		drain();

		while (live_count < LIVE_TARGET) begin
			steady = $urandom_range(0, 9) == 0;
			if (!hold_done && live_count >= 300) begin
				// receiver holds off while the sender keeps pushing
				hold_done    = 1'b1;
				steady       = 1'b1;
				hold_off_req = 1'b1;
				repeat (3) send_message(FAULT_NONE);
			end
			if (!drain_done && live_count >= 500) begin
				drain_done = 1'b1;
				drain();
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_message(FAULT_NONE);
			end else if (r < 90) begin
				send_message(msg_fault_t'($urandom_range(FAULT_BAD_CHAR, FAULT_NO_EOI)));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0);
			end
		end
		steady = 1'b0;
		drain();
		repeat (END_SETTLE) @(negedge clk);
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
